/* design/dual_pid_buck_duty_controller_defines.svh */
// Assertion macros used by the duty controller sequencer.
`ifndef DUAL_PID_BUCK_DUTY_CONTROLLER_DEFINES_SVH
`define DUAL_PID_BUCK_DUTY_CONTROLLER_DEFINES_SVH
`ifndef SYNTHESIS
// Check that a condition holds at every clock edge out of reset.
`define DPBD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition holds in the cycle after a trigger.
`define DPBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DPBD_ASSERT(lbl, clk, rst_n, prop, msg)
`define DPBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* design/dpbd_pkg.sv */
// Shared types, codes and constants of the dual loop duty controller.
package dpbd_pkg;

    // PWM counter period in clock ticks
    localparam int PWM_PERIOD = 1279;

    // Q24 clamp limits and fixed points
    localparam logic signed [31:0] VOLT_MAX = 32'sd16273899;
    localparam logic signed [31:0] VOLT_MIN = 32'sd838860;
    localparam logic signed [31:0] CURR_MAX = 32'sd11744051;
    localparam logic signed [31:0] CURR_MIN = 32'sd167772;
    localparam logic [23:0]        Q24_HALF = 24'd8388608;
    localparam logic [31:0]        Q24_ONE  = 32'd16777216;

    // Input word kinds
    localparam logic [1:0] OP_SAMPLE    = 2'd0;
    localparam logic [1:0] OP_POWER_ON  = 2'd1;
    localparam logic [1:0] OP_POWER_OFF = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_VOLT_GAIN0  = 3'd0;
    localparam logic [2:0] REG_VOLT_GAIN1  = 3'd1;
    localparam logic [2:0] REG_VOLT_GAIN2  = 3'd2;
    localparam logic [2:0] REG_CURR_GAIN0  = 3'd3;
    localparam logic [2:0] REG_CURR_GAIN1  = 3'd4;
    localparam logic [2:0] REG_CURR_GAIN2  = 3'd5;
    localparam logic [2:0] REG_VOLT_TARGET = 3'd6;
    localparam logic [2:0] REG_CURR_TARGET = 3'd7;

    // Loop coefficients and setpoints
    typedef struct packed {
        logic signed [31:0] volt_gain0;
        logic signed [31:0] volt_gain1;
        logic signed [31:0] volt_gain2;
        logic signed [31:0] curr_gain0;
        logic signed [31:0] curr_gain1;
        logic signed [31:0] curr_gain2;
        logic [24:0]        volt_target;
        logic [24:0]        curr_target;
    } t_cfg;

    // Accumulator control from the sequencer
    typedef struct packed {
        logic acc_ld;
        logic acc_add;
    } t_mac_ctl;

endpackage

/* design/dual_pid_buck_duty_controller.sv */
// Dual loop PID buck duty controller: stream ports, configuration registers, unit wiring.
// Each word on the input stream carries a kind in tuser (sample pair, power on,
// power off). A sample pair taken while power is on runs the voltage and current
// incremental PID loops one product at a time through a single registered 32x32
// multiplier and 64-bit accumulator, clamps both drives, picks the smaller as the
// duty and derives the PWM and ADC trigger compare values on the same multiplier.
// Power off emits duty zero; power on, samples while off and unknown kinds emit
// nothing. s_axis_tready is low while a word is being worked on, and the last
// step waits while the previous result still sits unread on the master side.
// Configuration writes are taken at any time and are meant for idle.
module dual_pid_buck_duty_controller import dpbd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // volt_sample[11:0], curr_sample[23:12]
    input  logic [1:0]  s_axis_tuser,   // op[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // duty_q24[23:0], main_compare[34:24],
                                        // trigger_compare[45:35], zero[47:46]
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    t_cfg               r_cfg;
    t_mac_ctl           w_mac_ctl;
    logic signed [31:0] w_mul_a, w_mul_b;
    logic signed [63:0] w_prod, w_acc;
    logic [23:0]        w_duty;
    logic [10:0]        w_main, w_trig;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.volt_gain0  <= 32'sd14260632;
            r_cfg.volt_gain1  <= -32'sd13421772;
            r_cfg.volt_gain2  <= 32'sd0;
            r_cfg.curr_gain0  <= 32'sd14260632;
            r_cfg.curr_gain1  <= -32'sd13421772;
            r_cfg.curr_gain2  <= 32'sd0;
            r_cfg.volt_target <= 25'd1677721;
            r_cfg.curr_target <= 25'd838860;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_VOLT_GAIN0:  r_cfg.volt_gain0  <= signed'(i_cfg_data);
                REG_VOLT_GAIN1:  r_cfg.volt_gain1  <= signed'(i_cfg_data);
                REG_VOLT_GAIN2:  r_cfg.volt_gain2  <= signed'(i_cfg_data);
                REG_CURR_GAIN0:  r_cfg.curr_gain0  <= signed'(i_cfg_data);
                REG_CURR_GAIN1:  r_cfg.curr_gain1  <= signed'(i_cfg_data);
                REG_CURR_GAIN2:  r_cfg.curr_gain2  <= signed'(i_cfg_data);
                REG_VOLT_TARGET: r_cfg.volt_target <= i_cfg_data[24:0];
                REG_CURR_TARGET: r_cfg.curr_target <= i_cfg_data[24:0];
                default: begin
                end
            endcase
        end
    end

    dpbd_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_op          (s_axis_tuser),
        .i_volt_sample (s_axis_tdata[11:0]),
        .i_curr_sample (s_axis_tdata[23:12]),
        .o_valid       (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_duty        (w_duty),
        .o_main        (w_main),
        .o_trig        (w_trig),
        .o_mac_ctl     (w_mac_ctl),
        .o_mul_a       (w_mul_a),
        .o_mul_b       (w_mul_b),
        .i_prod        (w_prod),
        .i_acc         (w_acc)
    );

    dpbd_mac u_mac (
        .i_clk   (i_clk),
        .i_ctl   (w_mac_ctl),
        .i_mul_a (w_mul_a),
        .i_mul_b (w_mul_b),
        .o_prod  (w_prod),
        .o_acc   (w_acc)
    );

    // Pack the result word
    assign m_axis_tdata = {2'b00, w_trig, w_main, w_duty};

endmodule

/* design/dpbd_mac.sv */
// Shared multiply-accumulate unit: registered 32x32 product and 64-bit accumulator.
module dpbd_mac import dpbd_pkg::*; (
    input  logic               i_clk,
    input  t_mac_ctl           i_ctl,
    input  logic signed [31:0] i_mul_a,
    input  logic signed [31:0] i_mul_b,
    output logic signed [63:0] o_prod,
    output logic signed [63:0] o_acc
);

    logic signed [63:0] r_prod;
    logic signed [63:0] r_acc;

    // Multiply every cycle, then load or add the product
    always_ff @(posedge i_clk) begin
        r_prod <= i_mul_a * i_mul_b;
        if (i_ctl.acc_ld) begin
            r_acc <= r_prod;
        end else if (i_ctl.acc_add) begin
            r_acc <= r_acc + r_prod;
        end
    end

    assign o_prod = r_prod;
    assign o_acc  = r_acc;

endmodule

/* design/dpbd_seq.sv */
// Step sequencer, loop state, clamping and result register of the duty controller.
`include "dual_pid_buck_duty_controller_defines.svh"
module dpbd_seq import dpbd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_op,
    input  logic [11:0]        i_volt_sample,
    input  logic [11:0]        i_curr_sample,
    output logic               o_valid,
    input  logic               i_out_ready,
    output logic [23:0]        o_duty,
    output logic [10:0]        o_main,
    output logic [10:0]        o_trig,
    output t_mac_ctl           o_mac_ctl,
    output logic signed [31:0] o_mul_a,
    output logic signed [31:0] o_mul_b,
    input  logic signed [63:0] i_prod,
    input  logic signed [63:0] i_acc
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    // Step codes
    localparam logic [3:0] S_V0   = 4'd0;
    localparam logic [3:0] S_V1   = 4'd1;
    localparam logic [3:0] S_V2   = 4'd2;
    localparam logic [3:0] S_C0   = 4'd3;
    localparam logic [3:0] S_VUPD = 4'd4;
    localparam logic [3:0] S_C2   = 4'd5;
    localparam logic [3:0] S_CADD = 4'd6;
    localparam logic [3:0] S_CUPD = 4'd7;
    localparam logic [3:0] S_DUTY = 4'd8;
    localparam logic [3:0] S_MAIN = 4'd9;
    localparam logic [3:0] S_TRIG = 4'd10;
    localparam logic [3:0] S_LOAD = 4'd11;

    localparam logic signed [31:0] PERIOD_MUL = 32'(PWM_PERIOD);
    localparam logic signed [31:0] HALF_MUL   = 32'((PWM_PERIOD + 1) / 2 - 1);

    localparam logic [23:0] VOLT_MAX24 = VOLT_MAX[23:0];
    localparam logic [23:0] VOLT_MIN24 = VOLT_MIN[23:0];
    localparam logic [23:0] CURR_MAX24 = CURR_MAX[23:0];
    localparam logic [23:0] CURR_MIN24 = CURR_MIN[23:0];

    logic               r_state, n_state;
    logic [3:0]         r_step, n_step;
    logic               r_out_valid, n_out_valid;
    logic               r_power;
    logic signed [25:0] r_verr0, r_verr1, r_cerr0, r_cerr1;
    logic [23:0]        r_vdrive, r_cdrive;
    logic [11:0]        r_vsamp, r_csamp;
    logic [23:0]        r_duty;
    logic [10:0]        r_main;
    logic [23:0]        r_out_duty;
    logic [10:0]        r_out_main, r_out_trig;

    logic               w_accept;
    logic               w_out_free;
    logic signed [25:0] w_ve0, w_ce0;
    logic [31:0]        w_trig_op;
    logic [23:0]        w_drive_in;
    logic signed [31:0] w_lo, w_hi;
    logic signed [31:0] w_dsum;
    logic [23:0]        w_clamped;

    assign o_ready    = (r_state == ST_IDLE);
    assign w_accept   = i_valid && o_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    // Newest errors from latched samples
    assign w_ve0 = signed'({1'b0, i_cfg.volt_target}) - signed'({2'b00, r_vsamp, 12'h000});
    assign w_ce0 = signed'({1'b0, i_cfg.curr_target}) - signed'({2'b00, r_csamp, 12'h000});

    // Trigger operand follows the half period rule
    assign w_trig_op = (r_duty > Q24_HALF) ? {8'h00, r_duty} : (Q24_ONE + {8'h00, r_duty});

    // Drive update: add the Q24 sum with 32-bit wrap, then clamp
    always_comb begin
        if (r_step == S_VUPD) begin
            w_drive_in = r_vdrive;
            w_lo       = VOLT_MIN;
            w_hi       = VOLT_MAX;
        end else begin
            w_drive_in = r_cdrive;
            w_lo       = CURR_MIN;
            w_hi       = CURR_MAX;
        end
        w_dsum = signed'({8'h00, w_drive_in}) + signed'(i_acc[55:24]);
        if (w_dsum > w_hi) begin
            w_clamped = w_hi[23:0];
        end else if (w_dsum < w_lo) begin
            w_clamped = w_lo[23:0];
        end else begin
            w_clamped = w_dsum[23:0];
        end
    end

    // Select multiplier operands and accumulator action per step
    always_comb begin
        o_mul_a           = '0;
        o_mul_b           = '0;
        o_mac_ctl.acc_ld  = 1'b0;
        o_mac_ctl.acc_add = 1'b0;
        if (r_state == ST_RUN) begin
            case (r_step)
                S_V0: begin
                    o_mul_a = i_cfg.volt_gain0;
                    o_mul_b = 32'(w_ve0);
                end
                S_V1: begin
                    o_mul_a          = i_cfg.volt_gain1;
                    o_mul_b          = 32'(r_verr0);
                    o_mac_ctl.acc_ld = 1'b1;
                end
                S_V2: begin
                    o_mul_a           = i_cfg.volt_gain2;
                    o_mul_b           = 32'(r_verr1);
                    o_mac_ctl.acc_add = 1'b1;
                end
                S_C0: begin
                    o_mul_a           = i_cfg.curr_gain0;
                    o_mul_b           = 32'(w_ce0);
                    o_mac_ctl.acc_add = 1'b1;
                end
                S_VUPD: begin
                    o_mul_a          = i_cfg.curr_gain1;
                    o_mul_b          = 32'(r_cerr0);
                    o_mac_ctl.acc_ld = 1'b1;
                end
                S_C2: begin
                    o_mul_a           = i_cfg.curr_gain2;
                    o_mul_b           = 32'(r_cerr1);
                    o_mac_ctl.acc_add = 1'b1;
                end
                S_CADD: begin
                    o_mac_ctl.acc_add = 1'b1;
                end
                S_MAIN: begin
                    o_mul_a = signed'({8'h00, r_duty});
                    o_mul_b = PERIOD_MUL;
                end
                S_TRIG, S_LOAD: begin
                    o_mul_a = signed'(w_trig_op);
                    o_mul_b = HALF_MUL;
                end
                default: begin
                end
            endcase
        end
    end

    // Next state, step and result valid
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_op == OP_SAMPLE && r_power) begin
                        n_state = ST_RUN;
                        n_step  = S_V0;
                    end else if (i_op == OP_POWER_OFF) begin
                        n_state = ST_RUN;
                        n_step  = S_MAIN;
                    end
                end
            end
            ST_RUN: begin
                if (r_step == S_LOAD) begin
                    if (w_out_free) begin
                        n_state     = ST_IDLE;
                        n_out_valid = 1'b1;
                    end
                end else begin
                    n_step = r_step + 4'd1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Advance sequencer and loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= S_V0;
            r_out_valid <= 1'b0;
            r_power     <= 1'b0;
            r_verr0     <= '0;
            r_verr1     <= '0;
            r_cerr0     <= '0;
            r_cerr1     <= '0;
            r_vdrive    <= '0;
            r_cdrive    <= '0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
            if (w_accept && i_op == OP_POWER_ON) begin
                r_power <= 1'b1;
            end
            if (w_accept && i_op == OP_POWER_OFF) begin
                r_power  <= 1'b0;
                r_verr0  <= '0;
                r_verr1  <= '0;
                r_vdrive <= '0;
            end
            if (r_state == ST_RUN && r_step == S_VUPD) begin
                r_vdrive <= w_clamped;
                r_verr1  <= r_verr0;
                r_verr0  <= w_ve0;
            end
            if (r_state == ST_RUN && r_step == S_CUPD) begin
                r_cdrive <= w_clamped;
                r_cerr1  <= r_cerr0;
                r_cerr0  <= w_ce0;
            end
        end
    end

    // Hold samples, duty and compare values
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_vsamp <= i_volt_sample;
            r_csamp <= i_curr_sample;
            if (i_op == OP_POWER_OFF) begin
                r_duty <= '0;
            end
        end
        if (r_state == ST_RUN && r_step == S_DUTY) begin
            r_duty <= (r_cdrive > r_vdrive) ? r_vdrive : r_cdrive;
        end
        if (r_state == ST_RUN && r_step == S_TRIG) begin
            r_main <= i_prod[34:24];
        end
        if (r_state == ST_RUN && r_step == S_LOAD && w_out_free) begin
            r_out_duty <= r_duty;
            r_out_main <= r_main;
            r_out_trig <= i_prod[34:24];
        end
    end

    assign o_valid = r_out_valid;
    assign o_duty  = r_out_duty;
    assign o_main  = r_out_main;
    assign o_trig  = r_out_trig;

    `DPBD_ASSERT(a_vdrive_range, i_clk, i_rst_n, (r_vdrive == '0) || (r_vdrive >= VOLT_MIN24 && r_vdrive <= VOLT_MAX24), "voltage drive left its clamp range")
    `DPBD_ASSERT(a_cdrive_range, i_clk, i_rst_n, (r_cdrive == '0) || (r_cdrive >= CURR_MIN24 && r_cdrive <= CURR_MAX24), "current drive left its clamp range")
    `DPBD_ASSERT(a_duty_min, i_clk, i_rst_n, !(r_state == ST_RUN && r_step == S_MAIN && r_vdrive != '0) || (r_duty <= r_vdrive && r_duty <= r_cdrive), "duty is not the smaller drive")
    `DPBD_ASSERT_NEXT(a_load_done, i_clk, i_rst_n, r_state == ST_RUN && r_step == S_LOAD && w_out_free, r_out_valid && r_state == ST_IDLE, "result load did not publish the word")

endmodule
